[sv/ksb_pkg.sv]
// Shared types, constants and helpers for the kinematic step block.
`timescale 1ns / 1ps

package ksb_pkg;

    // Fixed-point limits and constants
    localparam logic [16:0] DT_MAX    = 17'd65536;   // 1.0 s in Q16.16
    localparam logic [19:0] ROLL_GAIN = 20'd597617;  // 180/(2*pi^2) in Q16.16
    localparam int          DIV_BITS  = 51;          // magnitude bits of the roll dividend
    localparam int          CNT_W     = $clog2(DIV_BITS);

    // Register reset values
    localparam logic signed [31:0] RST_ACCEL_X = 32'sd0;
    localparam logic signed [31:0] RST_ACCEL_Y = -32'sd642908;
    localparam logic signed [31:0] RST_ACCEL_Z = 32'sd0;
    localparam logic        [30:0] RST_RADIUS  = 31'd65536;
    localparam logic signed [31:0] RST_FLOOR_Y = 32'sd163840;
    localparam logic signed [31:0] RST_ROOF_Y  = 32'sd983040;
    localparam logic signed [31:0] RST_LEFT_X  = 32'sd0;
    localparam logic signed [31:0] RST_RIGHT_X = 32'sd1802240;

    // Body state reset values
    localparam logic signed [31:0] RST_POS_X = 32'sd131072;
    localparam logic signed [31:0] RST_POS_Y = 32'sd819200;
    localparam logic signed [31:0] RST_VEL_X = 32'sd983040;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADT,
        S_VDT,
        S_ATT,
        S_UPD,
        S_DMUL,
        S_GAIN,
        S_DIVINIT,
        S_DIV,
        S_ROLL,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    typedef enum logic [2:0] {
        MS_ACC,
        MS_VEL,
        MS_ADT,
        MS_VX,
        MS_GAIN
    } t_mul_sel;

    typedef enum logic [2:0] {
        CFG_ACCEL_X,
        CFG_ACCEL_Y,
        CFG_ACCEL_Z,
        CFG_RADIUS,
        CFG_FLOOR_Y,
        CFG_ROOF_Y,
        CFG_LEFT_X,
        CFG_RIGHT_X
    } t_cfg_idx;

    // Controller to datapath
    typedef struct packed {
        logic     load_dt;
        t_mul_sel mul_sel;
        t_axis    axis;
        logic     st_adt;
        logic     st_acc;
        logic     st_upd;
        logic     clamp_a;
        logic     clamp_b;
        logic     div_step;
        logic     roll_upd;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
    } t_sts;

    // Saturate a 33-bit sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
        logic signed [31:0] res;
        if (x > 33'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < -33'sh0_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    // Negate with saturation (most negative value maps to most positive)
    function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] x);
        logic signed [31:0] res;
        if (x == 32'sh8000_0000) begin
            res = 32'sh7FFF_FFFF;
        end else begin
            res = -x;
        end
        return res;
    endfunction

endpackage

[sv/ksb_ctrl.sv]
// Sequencer for one time step: multiplies, clamps, roll division, result hand-off.
`timescale 1ns / 1ps

module ksb_ctrl
    import ksb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_axis  r_axis, n_axis;

    // State and axis registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= AX_X;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_axis        = r_axis;
        o_cmd         = '0;
        o_cmd.mul_sel = MS_ACC;
        o_cmd.axis    = r_axis;
        o_ready       = 1'b0;
        o_valid       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_dt = 1'b1;
                    n_axis        = AX_X;
                    n_state       = S_ADT;
                end
            end
            S_ADT: begin
                o_cmd.mul_sel = MS_ACC;
                n_state       = S_VDT;
            end
            S_VDT: begin
                o_cmd.st_adt  = 1'b1;
                o_cmd.mul_sel = MS_VEL;
                n_state       = S_ATT;
            end
            S_ATT: begin
                o_cmd.st_acc  = 1'b1;
                o_cmd.mul_sel = MS_ADT;
                n_state       = S_UPD;
            end
            S_UPD: begin
                o_cmd.st_upd = 1'b1;
                unique case (r_axis)
                    AX_X: begin
                        n_axis  = AX_Y;
                        n_state = S_ADT;
                    end
                    AX_Y: begin
                        n_axis  = AX_Z;
                        n_state = S_ADT;
                    end
                    default: begin
                        n_state = S_DMUL;
                    end
                endcase
            end
            S_DMUL: begin
                o_cmd.mul_sel = MS_VX;
                n_state       = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.mul_sel = MS_GAIN;
                o_cmd.clamp_a = 1'b1;
                n_state       = S_DIVINIT;
            end
            S_DIVINIT: begin
                o_cmd.clamp_b = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_ROLL;
                end
            end
            S_ROLL: begin
                o_cmd.roll_upd = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready and valid high together");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_ADT && r_axis == AX_X))
        else $error("accepted item did not start the x axis");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_ROLL))
        else $error("divider finish not followed by roll update");

    a_out_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> (o_ready && !o_valid))
        else $error("delivered result did not return to idle");

endmodule

[sv/ksb_dp.sv]
// Datapath: config registers, body state, shared multiplier, clamps, roll divider.
`timescale 1ns / 1ps

module ksb_dp
    import ksb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic [16:0]        i_step_time,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_z,
    output logic signed [31:0] o_roll
);

    // Configuration
    logic signed [31:0] r_accel_x, r_accel_y, r_accel_z;
    logic        [30:0] r_radius;
    logic signed [31:0] r_floor_y, r_roof_y, r_left_x, r_right_x;

    // Body state
    logic signed [31:0] r_pos_x, r_pos_y, r_pos_z;
    logic signed [31:0] r_vel_x, r_vel_y, r_vel_z;
    logic signed [31:0] r_roll;

    // Working registers
    logic        [16:0] r_dt;
    logic signed [52:0] r_prod;
    logic signed [31:0] r_adt;
    logic signed [33:0] r_acc;
    logic signed [33:0] r_pw_x, r_pw_y;
    logic signed [31:0] r_vy_mid;
    logic        [31:0] r_rem;
    logic        [DIV_BITS-1:0] r_quo;
    logic        [30:0] r_den;
    logic               r_neg;
    logic        [CNT_W-1:0] r_div_cnt;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_x <= RST_ACCEL_X;
            r_accel_y <= RST_ACCEL_Y;
            r_accel_z <= RST_ACCEL_Z;
            r_radius  <= RST_RADIUS;
            r_floor_y <= RST_FLOOR_Y;
            r_roof_y  <= RST_ROOF_Y;
            r_left_x  <= RST_LEFT_X;
            r_right_x <= RST_RIGHT_X;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ACCEL_X: r_accel_x <= i_cfg_data;
                CFG_ACCEL_Y: r_accel_y <= i_cfg_data;
                CFG_ACCEL_Z: r_accel_z <= i_cfg_data;
                CFG_RADIUS:  r_radius  <= i_cfg_data[30:0];
                CFG_FLOOR_Y: r_floor_y <= i_cfg_data;
                CFG_ROOF_Y:  r_roof_y  <= i_cfg_data;
                CFG_LEFT_X:  r_left_x  <= i_cfg_data;
                CFG_RIGHT_X: r_right_x <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-axis selects
    logic signed [31:0] sel_acc, sel_vel, sel_pos;
    always_comb begin
        case (i_cmd.axis)
            AX_X: begin
                sel_acc = r_accel_x;
                sel_vel = r_vel_x;
                sel_pos = r_pos_x;
            end
            AX_Y: begin
                sel_acc = r_accel_y;
                sel_vel = r_vel_y;
                sel_pos = r_pos_y;
            end
            default: begin
                sel_acc = r_accel_z;
                sel_vel = r_vel_z;
                sel_pos = r_pos_z;
            end
        endcase
    end

    // Shared multiplier operands: 32-bit signed by 21-bit signed
    logic signed [31:0] mul_a;
    logic signed [20:0] mul_b;
    always_comb begin
        mul_b = $signed({4'b0, r_dt});
        case (i_cmd.mul_sel)
            MS_ACC:  mul_a = sel_acc;
            MS_VEL:  mul_a = sel_vel;
            MS_ADT:  mul_a = r_adt;
            MS_VX:   mul_a = r_vel_x;
            MS_GAIN: begin
                mul_a = r_prod[47:16];
                mul_b = $signed({1'b0, ROLL_GAIN});
            end
            default: mul_a = sel_acc;
        endcase
    end

    // Floor-shifted product views
    logic signed [31:0] prod_s16, prod_s17;
    assign prod_s16 = r_prod[47:16];
    assign prod_s17 = r_prod[48:17];

    // Integration sums
    logic signed [33:0] acc_sum, pw_sum;
    logic signed [32:0] vel_sum;
    logic signed [31:0] vel_new;
    assign acc_sum = {{2{sel_pos[31]}}, sel_pos} + {{2{prod_s16[31]}}, prod_s16};
    assign pw_sum  = r_acc + {{2{prod_s17[31]}}, prod_s17};
    assign vel_sum = {sel_vel[31], sel_vel} + {r_adt[31], r_adt};
    assign vel_new = sat32(vel_sum);

    // Divider trial subtract and roll increment
    logic [32:0] div_trial;
    logic [31:0] roll_inc;
    logic signed [52:0] prod_neg;
    assign div_trial = {r_rem, r_quo[DIV_BITS-1]} - {2'b0, r_den};
    assign roll_inc  = r_neg ? (~r_quo[31:0] + 32'd1) : r_quo[31:0];
    assign prod_neg  = -r_prod;
    assign o_sts.div_last = (r_div_cnt == CNT_W'(DIV_BITS - 1));

    // Multiplier, integration and dt registers (no reset needed)
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.load_dt) begin
            r_dt <= (i_step_time > DT_MAX) ? DT_MAX : i_step_time;
        end
        if (i_cmd.st_adt) begin
            r_adt <= prod_s16;
        end
        if (i_cmd.st_acc) begin
            r_acc <= acc_sum;
        end
        if (i_cmd.st_upd) begin
            case (i_cmd.axis)
                AX_X:    r_pw_x <= pw_sum;
                AX_Y:    r_pw_y <= pw_sum;
                default: ;
            endcase
        end
        // Roof clamp result for y, checked against the floor next
        if (i_cmd.clamp_a) begin
            if (r_pw_y > r_roof_y) begin
                r_pw_y   <= {{2{r_roof_y[31]}}, r_roof_y};
                r_vy_mid <= neg_sat32(r_vel_y);
            end else begin
                r_vy_mid <= r_vel_y;
            end
        end
        // Divider load and iteration
        if (i_cmd.clamp_b) begin
            r_neg     <= r_prod[52];
            r_quo     <= r_prod[52] ? prod_neg[DIV_BITS-1:0] : r_prod[DIV_BITS-1:0];
            r_rem     <= '0;
            r_den     <= (r_radius == '0) ? 31'd1 : r_radius;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!div_trial[32]) begin
                r_rem <= div_trial[31:0];
                r_quo <= {r_quo[DIV_BITS-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_quo[DIV_BITS-1]};
                r_quo <= {r_quo[DIV_BITS-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + CNT_W'(1);
        end
    end

    // Body state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= RST_POS_X;
            r_pos_y <= RST_POS_Y;
            r_pos_z <= '0;
            r_vel_x <= RST_VEL_X;
            r_vel_y <= '0;
            r_vel_z <= '0;
            r_roll  <= '0;
        end else begin
            // Velocity update; z position wraps
            if (i_cmd.st_upd) begin
                case (i_cmd.axis)
                    AX_X: r_vel_x <= vel_new;
                    AX_Y: r_vel_y <= vel_new;
                    default: begin
                        r_vel_z <= vel_new;
                        r_pos_z <= pw_sum[31:0];
                    end
                endcase
            end
            // Walls in x: right first, else left
            if (i_cmd.clamp_a) begin
                if (r_pw_x > r_right_x) begin
                    r_pos_x <= r_right_x;
                    r_vel_x <= neg_sat32(r_vel_x);
                end else if (r_pw_x < r_left_x) begin
                    r_pos_x <= r_left_x;
                    r_vel_x <= neg_sat32(r_vel_x);
                end else begin
                    r_pos_x <= r_pw_x[31:0];
                end
            end
            // Floor clamp in y after the roof clamp
            if (i_cmd.clamp_b) begin
                if (r_pw_y < r_floor_y) begin
                    r_pos_y <= r_floor_y;
                    r_vel_y <= neg_sat32(r_vy_mid);
                end else begin
                    r_pos_y <= r_pw_y[31:0];
                    r_vel_y <= r_vy_mid;
                end
            end
            if (i_cmd.roll_upd) begin
                r_roll <= r_roll + roll_inc;
            end
        end
    end

    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;
    assign o_pos_z = r_pos_z;
    assign o_vel_x = r_vel_x;
    assign o_vel_y = r_vel_y;
    assign o_vel_z = r_vel_z;
    assign o_roll  = r_roll;

endmodule

[sv/kinematic_step_with_wall_bounce.sv]
// Top level of the kinematic step block with wall bounce.
`timescale 1ns / 1ps

// Each accepted item is one time step dt (unsigned Q16.16, values above 1.0
// are taken as 1.0). The block advances the stored position and velocity of
// the body on all three axes, clamps y to floor and roof and x to the walls
// (negating the velocity on each bounce), adds the roll angle and presents the
// full state as one result. One item is in work at a time: o_valid rises once
// the roll update of the accepted item is done, and o_ready returns the cycle
// after the result is taken. The shared 32x21 multiplier passes over the three
// axes in turn, and the bit-serial divider scales the roll increment by the
// radius. Configuration registers (index 0..7: accel_x, accel_y, accel_z,
// wheel_radius, floor_y, roof_y, left_x, right_x) take effect on the next item
// and should be written while the block is idle.

module kinematic_step_with_wall_bounce
    import ksb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [16:0]        i_step_time,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [31:0] o_out_vel_x,
    output logic signed [31:0] o_out_vel_y,
    output logic signed [31:0] o_out_vel_z,
    output logic signed [31:0] o_out_roll_deg
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    ksb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Arithmetic and state
    ksb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_step_time (i_step_time),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_pos_x     (o_out_pos_x),
        .o_pos_y     (o_out_pos_y),
        .o_pos_z     (o_out_pos_z),
        .o_vel_x     (o_out_vel_x),
        .o_vel_y     (o_out_vel_y),
        .o_vel_z     (o_out_vel_z),
        .o_roll      (o_out_roll_deg)
    );

endmodule

[dv/kinematic_step_with_wall_bounce_test.sv]
// Self-checking testbench for the kinematic step block with wall bounce.
`timescale 1ns / 1ps

module kinematic_step_with_wall_bounce_test;
    import ksb_pkg::*;

    localparam int     STEP_CYCLES   = 69;     // span of one item, accept to next accept
    localparam int     HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int     RANDOM_PHASES = 12;
    localparam int     PRINT_LIMIT   = 40;
    localparam longint S32_MAX       = 64'sd2147483647;
    localparam longint S32_MIN       = -64'sd2147483648;

    // [0..2] position x/y/z, [3..5] velocity x/y/z, [6] roll angle
    typedef logic [6:0][31:0] t_body_vec;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_we       = 1'b0;
    logic [2:0]         i_cfg_idx      = '0;
    logic [31:0]        i_cfg_data     = '0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [16:0]        i_step_time    = '0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic signed [31:0] o_out_pos_x;
    logic signed [31:0] o_out_pos_y;
    logic signed [31:0] o_out_pos_z;
    logic signed [31:0] o_out_vel_x;
    logic signed [31:0] o_out_vel_y;
    logic signed [31:0] o_out_vel_z;
    logic signed [31:0] o_out_roll_deg;

    logic [16:0] steps_pending [$];
    t_body_vec   states_due [$];
    int          src_idle_pct  = 28;
    int          sink_idle_pct = 28;
    int          hold_asked    = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          fail_count    = 0;
    int          result_count  = 0;
    string       field_names [7] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                                     "roll_deg"};

    // Shadow copy of the registers
    longint cfg_acc [3] = '{longint'(RST_ACCEL_X), longint'(RST_ACCEL_Y),
                            longint'(RST_ACCEL_Z)};
    longint cfg_radius  = longint'(RST_RADIUS);
    longint cfg_floor   = longint'(RST_FLOOR_Y);
    longint cfg_roof    = longint'(RST_ROOF_Y);
    longint cfg_left    = longint'(RST_LEFT_X);
    longint cfg_right   = longint'(RST_RIGHT_X);

    // Body state as the block should hold it
    longint body_pos [3] = '{longint'(RST_POS_X), longint'(RST_POS_Y), 64'sd0};
    longint body_vel [3] = '{longint'(RST_VEL_X), 64'sd0, 64'sd0};
    longint body_roll    = 64'sd0;

    kinematic_step_with_wall_bounce i_dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic longint clip32(input longint x);
        longint res;
        res = x;
        if (x > S32_MAX) begin
            res = S32_MAX;
        end else if (x < S32_MIN) begin
            res = S32_MIN;
        end
        return res;
    endfunction

    function automatic longint wrap32(input longint x);
        return longint'($signed(x[31:0]));
    endfunction

    // Advance the body by one time step and return the state it should report
    function automatic t_body_vec advance_body(input logic [16:0] step);
        longint    dt;
        longint    adt;
        longint    inc;
        longint    rad;
        int        k;
        t_body_vec res;
        dt = (step > DT_MAX) ? longint'(DT_MAX) : longint'(step);
        // position uses the old velocity, then velocity takes a*dt
        for (k = 0; k < 3; k++) begin
            adt = (cfg_acc[k] * dt) >>> 16;
            body_pos[k] = body_pos[k] + ((body_vel[k] * dt) >>> 16) + ((adt * dt) >>> 17);
            body_vel[k] = clip32(body_vel[k] + adt);
        end
        body_pos[2] = wrap32(body_pos[2]);
        // roll from the new vx, before any bounce; zero radius acts as one
        rad = (cfg_radius == 0) ? 64'sd1 : cfg_radius;
        inc = (((body_vel[0] * dt) >>> 16) * longint'(ROLL_GAIN)) / rad;
        body_roll = wrap32(body_roll + inc);
        // y: roof then floor, both fire when the body passes a roof that is below the floor
        if (body_pos[1] > cfg_roof) begin
            body_vel[1] = clip32(-body_vel[1]);
            body_pos[1] = cfg_roof;
        end
        if (body_pos[1] < cfg_floor) begin
            body_vel[1] = clip32(-body_vel[1]);
            body_pos[1] = cfg_floor;
        end
        // x: right wall, else left wall
        if (body_pos[0] > cfg_right) begin
            body_vel[0] = clip32(-body_vel[0]);
            body_pos[0] = cfg_right;
        end else if (body_pos[0] < cfg_left) begin
            body_vel[0] = clip32(-body_vel[0]);
            body_pos[0] = cfg_left;
        end
        for (k = 0; k < 3; k++) begin
            res[k]     = body_pos[k][31:0];
            res[k + 3] = body_vel[k][31:0];
        end
        res[6] = body_roll[31:0];
        return res;
    endfunction

    task automatic report_error(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // Register write, only issued while the block is idle
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ACCEL_X: cfg_acc[0] = longint'($signed(data));
            CFG_ACCEL_Y: cfg_acc[1] = longint'($signed(data));
            CFG_ACCEL_Z: cfg_acc[2] = longint'($signed(data));
            CFG_RADIUS:  cfg_radius = longint'(data[30:0]);
            CFG_FLOOR_Y: cfg_floor  = longint'($signed(data));
            CFG_ROOF_Y:  cfg_roof   = longint'($signed(data));
            CFG_LEFT_X:  cfg_left   = longint'($signed(data));
            CFG_RIGHT_X: cfg_right  = longint'($signed(data));
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do @(negedge i_clk);
        while (steps_pending.size() != 0 || i_valid || states_due.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    // Register value: plausible scene, or anything at all
    function automatic logic [31:0] pick_reg(input t_cfg_idx idx, input bit wild);
        logic [31:0] v;
        if (wild) begin
            case ($urandom_range(3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                default: v = $urandom();
            endcase
        end else begin
            case (idx)
                CFG_ACCEL_X, CFG_ACCEL_Y, CFG_ACCEL_Z: v = $urandom_range(2621440) - 1310720;
                CFG_RADIUS:              v = $urandom_range(262144, 6554);
                CFG_FLOOR_Y, CFG_LEFT_X: v = $urandom_range(655360) - 655360;
                CFG_ROOF_Y:              v = $urandom_range(1638400, 131072);
                default:                 v = $urandom_range(2621440, 327680);
            endcase
        end
        return v;
    endfunction

    // Driver: next step time goes out once the current item is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (steps_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                i_valid     <= 1'b1;
                i_step_time <= steps_pending.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus requested long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready     <= 1'b0;
            hold_left   <= 0;
            hold_served <= 0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            i_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Monitor: predict on each accepted item, check each accepted result
    always @(posedge i_clk) begin : monitor
        t_body_vec seen;
        t_body_vec want;
        int        k;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                states_due.push_back(advance_body(i_step_time));
            end
            if (o_valid && i_ready) begin
                seen = {o_out_roll_deg, o_out_vel_z, o_out_vel_y, o_out_vel_x,
                        o_out_pos_z, o_out_pos_y, o_out_pos_x};
                if (states_due.size() == 0) begin
                    report_error($sformatf("result %0d with no item outstanding",
                                           result_count));
                end else begin
                    want = states_due.pop_front();
                    for (k = 0; k < 7; k++) begin
                        if (seen[k] !== want[k]) begin
                            report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, field_names[k], $signed(seen[k]),
                                $signed(want[k])));
                        end
                    end
                end
                result_count++;
            end
        end
    end

    initial begin : stimulus
        int          ph;
        int          n;
        int          k;
        int          r;
        bit          wild;
        logic [16:0] step;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero step, tiny, one second, too long, full 17 bits
        @(negedge i_clk);
        steps_pending = '{17'd0, 17'd1, 17'd65535, 17'd65536, 17'd65537, 17'd131071,
                          17'd32768, 17'd1000};
        wait_drained();

        // Extremes: velocities saturate, bounce from most negative vy,
        // z and roll wrap, zero radius (top bit of the write is dropped)
        write_reg(CFG_ACCEL_X, 32'h7FFF_FFFF);
        write_reg(CFG_ACCEL_Y, 32'h8000_0000);
        write_reg(CFG_ACCEL_Z, 32'h7FFF_FFFF);
        write_reg(CFG_RADIUS,  32'h8000_0000);
        write_reg(CFG_FLOOR_Y, 32'h0000_0000);
        write_reg(CFG_ROOF_Y,  32'h7FFF_FFFF);
        write_reg(CFG_LEFT_X,  32'h8000_0000);
        write_reg(CFG_RIGHT_X, 32'h7FFF_FFFF);
        @(negedge i_clk);
        steps_pending = '{17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
                          17'd131071};
        wait_drained();

        // Roof below floor, both x walls, widest radius
        write_reg(CFG_ACCEL_X, -32'sd3276800);
        write_reg(CFG_ACCEL_Y, -32'sd642908);
        write_reg(CFG_ACCEL_Z, 32'h0000_0000);
        write_reg(CFG_RADIUS,  32'h7FFF_FFFF);
        write_reg(CFG_FLOOR_Y, 32'sd327680);
        write_reg(CFG_ROOF_Y,  32'sd65536);
        write_reg(CFG_LEFT_X,  -32'sd196608);
        write_reg(CFG_RIGHT_X, 32'sd6553600);
        @(negedge i_clk);
        steps_pending = '{17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
                          17'd65536};
        wait_drained();

        // Random phases, each starting from an idle block
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            wild = (ph == 3 || ph == 8);
            for (r = 0; r < 8; r++) begin
                if (ph == 0 || wild || $urandom_range(9) < 6) begin
                    write_reg(t_cfg_idx'(r), pick_reg(t_cfg_idx'(r), wild));
                end
            end
            @(negedge i_clk);
            src_idle_pct  = (ph == 5) ? 0 : 28;
            sink_idle_pct = (ph == 5) ? 0 : 28;
            if (ph == 2) begin
                hold_asked++;
            end
            n = $urandom_range(70, 45);
            for (k = 0; k < n; k++) begin
                case ($urandom_range(9))
                    0:       step = $urandom_range(131071, 65537);
                    1, 2:    step = $urandom_range(65536, 8193);
                    default: step = $urandom_range(8192);
                endcase
                steps_pending.push_back(step);
            end
            wait_drained();
        end

        repeat (STEP_CYCLES + 11) @(posedge i_clk);
        if (states_due.size() != 0) begin
            report_error($sformatf("%0d results never arrived", states_due.size()));
        end
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hang guard, far above the slowest correct run
    initial begin : watchdog
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

[kinematic_step_with_wall_bounce.f]
sv/ksb_pkg.sv
sv/ksb_ctrl.sv
sv/ksb_dp.sv
sv/kinematic_step_with_wall_bounce.sv
dv/kinematic_step_with_wall_bounce_test.sv
